>>> src/rprc_pkg.sv
// rprc_pkg: shared types, constants and the crc-8 helper of the ring packet receiver
// used by every module under src
package rprc_pkg;

  localparam int MAX_DEVICES = 4;
  localparam int ADDR_REGS   = 4;
  localparam int ADDR_USED   = (MAX_DEVICES < ADDR_REGS) ? MAX_DEVICES : ADDR_REGS;
  localparam int RX_DEPTH    = 16;
  localparam int WIPE_LEN    = 16;
  localparam int OUT_LIMIT   = 16;
  localparam int WIPE_CNT    = (WIPE_LEN < OUT_LIMIT) ? WIPE_LEN : OUT_LIMIT;
  localparam int MSG_LEN     = 6;

  localparam logic [7:0] SYNC_VALUE = 8'd84;
  localparam logic [7:0] HDR_ACK    = 8'h52;
  localparam logic [7:0] HDR_NAK    = 8'h53;
  localparam logic [7:0] HDR2_VALUE = 8'h50;
  localparam logic [7:0] HDR2_MASK  = 8'hfc;
  localparam logic [7:0] HDR1_VALUE = 8'h30;
  localparam logic [7:0] HDR1_MASK  = 8'hf0;

  localparam logic [7:0] CRC_TAB [8] = '{8'h5e, 8'hbc, 8'h61, 8'hc2,
                                         8'h9d, 8'h23, 8'h46, 8'h8c};

  // input modes
  localparam logic [1:0] MODE_LINE    = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;

  // register indexes on the apb port
  localparam logic [2:0] REG_COUNT = 3'd0;
  localparam logic [2:0] REG_ADDR0 = 3'd1;
  localparam logic [2:0] REG_ADDR1 = 3'd2;
  localparam logic [2:0] REG_ADDR2 = 3'd3;
  localparam logic [2:0] REG_ADDR3 = 3'd4;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx_byte;
    logic [3:0] read_index;
  } rprc_in_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       last;
    logic       packet_ready;
    logic [7:0] read_data;
    logic [7:0] dest_address;
    logic [7:0] src_address;
    logic [4:0] payload_length;
    logic       passing_through;
  } rprc_out_t;

  typedef struct packed {
    logic [2:0]                 count;
    logic [ADDR_REGS-1:0][7:0] addr;
  } rprc_cfg_t;

  typedef struct packed {
    logic       en;
    logic [3:0] addr;
    logic [7:0] data;
  } rprc_wr_t;

  // one burst of result items plus the status after the transfer
  typedef struct packed {
    logic                     tx_valid;
    logic [3:0]               last_idx;
    logic [MSG_LEN-1:0][7:0] msg;
    logic                     lock;
    logic [7:0]               dest;
    logic [7:0]               src;
    logic [4:0]               len;
    logic                     pass;
  } rprc_job_t;

  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] x;
    logic [7:0] r;
    x = b ^ crc;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (x[i]) r = r ^ CRC_TAB[i];
    end
    return r;
  endfunction

endpackage

>>> src/ring_packet_receiver_crc8.sv
// ring_packet_receiver_crc8: receiver for a ring packet protocol with crc-8 check
// Input channel (in_valid_i / in_stall_o / in_data_i): one transfer carries a line
// byte, a lock release or a payload read request. Output channel (out_valid_o /
// out_stall_i / out_data_o): each input transfer yields 1 to 16 result items,
// the final one flagged by last; status fields show the state after the input.
// The first result item is valid in the cycle after the input transfer.
// Throughput: one result item per cycle while out_stall_i is low; an input yields
// 1 result item for most bytes, 4 when forwarding starts, 6 for an ack or
// nak frame, 16 for a wipe burst. The burst register in rprc_tx plays these out;
// a new input is taken in the same cycle as the final item of the previous one.
// The payload buffer is a 16 x 8 synchronous memory read once per input transfer,
// with the byte written by the same transfer forwarded to the read.
// The apb port sets the own address count and the four own addresses.
// Reset clears the frame state, flags and registers; the payload buffer holds
// no defined data until written. While out_stall_i is high the current item
// holds and in_stall_o stays high.
// depends on rprc_pkg and the rprc_* modules
module ring_packet_receiver_crc8
  import rprc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  rprc_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output rprc_out_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  rprc_cfg_t  cfg;
  rprc_wr_t   wr;
  rprc_job_t  job;
  logic       accept, busy;
  logic [7:0] rd_data;

  assign in_stall_o = busy;
  assign accept     = in_valid_i & ~busy;

  rprc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rprc_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_data_i),
    .cfg_i    (cfg),
    .wr_o     (wr),
    .job_o    (job)
  );

  rprc_payload_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (accept),
    .rd_addr_i (in_data_i.read_index),
    .rd_data_o (rd_data)
  );

  rprc_tx u_tx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .job_i       (job),
    .rd_data_i   (rd_data),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> src/rprc_regs.sv
// rprc_regs: apb register file holding the own address count and own addresses
// depends on rprc_pkg
module rprc_regs
  import rprc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output rprc_cfg_t   cfg_o
);

  rprc_cfg_t cfg_q, cfg_d;
  logic      wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (paddr[4:2])
        REG_COUNT: cfg_d.count   = pwdata[2:0];
        REG_ADDR0: cfg_d.addr[0] = pwdata[7:0];
        REG_ADDR1: cfg_d.addr[1] = pwdata[7:0];
        REG_ADDR2: cfg_d.addr[2] = pwdata[7:0];
        REG_ADDR3: cfg_d.addr[3] = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_COUNT: prdata = {29'd0, cfg_q.count};
      REG_ADDR0: prdata = {24'd0, cfg_q.addr[0]};
      REG_ADDR1: prdata = {24'd0, cfg_q.addr[1]};
      REG_ADDR2: prdata = {24'd0, cfg_q.addr[2]};
      REG_ADDR3: prdata = {24'd0, cfg_q.addr[3]};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> src/rprc_payload_ram.sv
// rprc_payload_ram: payload buffer, one write and one registered read per cycle
// depends on rprc_pkg
module rprc_payload_ram
  import rprc_pkg::*;
(
  input  logic       clk_i,
  input  rprc_wr_t   wr_i,
  input  logic       rd_en_i,
  input  logic [3:0] rd_addr_i,
  output logic [7:0] rd_data_o
);

  logic [7:0] mem [RX_DEPTH];
  logic [7:0] rd_data_q;

  assign rd_data_o = rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // a read of the entry written in the same cycle sees the new byte
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_i.en && wr_i.addr == rd_addr_i) begin
        rd_data_q <= wr_i.data;
      end else begin
        rd_data_q <= mem[rd_addr_i];
      end
    end
  end

endmodule

>>> src/rprc_parser.sv
// rprc_parser: frame state machine, crc check, address match and reply framing
// depends on rprc_pkg; writes the payload buffer and hands a burst to rprc_tx
module rprc_parser
  import rprc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  rprc_in_t  in_i,
  input  rprc_cfg_t cfg_i,
  output rprc_wr_t  wr_o,
  output rprc_job_t job_o
);

  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_SYNC      = 4'd1;
  localparam logic [3:0] PH_HDR2      = 4'd2;
  localparam logic [3:0] PH_HDR1      = 4'd3;
  localparam logic [3:0] PH_DEST      = 4'd4;
  localparam logic [3:0] PH_DATA      = 4'd5;
  localparam logic [3:0] PH_CRC       = 4'd6;
  localparam logic [3:0] PH_PASS_SRC  = 4'd7;
  localparam logic [3:0] PH_PASS_DATA = 4'd8;

  localparam logic [4:0] DEPTH_L = 5'(RX_DEPTH);

  logic [3:0] phase_q, phase_d;
  logic [7:0] crc_q, crc_d, hdr2_q, hdr2_d, hdr1_q, hdr1_d;
  logic [7:0] dest_q, dest_d, src_q, src_d;
  logic [4:0] len_q, len_d, fill_q, fill_d;
  logic       ack_q, ack_d, lock_q, lock_d, abort_q, abort_d, pass_q, pass_d;

  logic [7:0] c;
  logic [2:0] n_used;
  logic       ours, bad, do_reply;
  logic [7:0] reply_hdr, c1, c2, c3, c4;
  logic [4:0] lenv;

  assign c = in_i.rx_byte;

  always_comb begin
    n_used = (cfg_i.count > 3'(ADDR_USED)) ? 3'(ADDR_USED) : cfg_i.count;
    ours   = 1'b0;
    for (int i = 0; i < ADDR_REGS; i++) begin
      if (3'(i) < n_used && cfg_i.addr[i] == c) ours = 1'b1;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    crc_d     = crc_q;
    hdr2_d    = hdr2_q;
    hdr1_d    = hdr1_q;
    dest_d    = dest_q;
    src_d     = src_q;
    len_d     = len_q;
    fill_d    = fill_q;
    ack_d     = ack_q;
    lock_d    = lock_q;
    abort_d   = abort_q;
    pass_d    = pass_q;
    bad       = 1'b0;
    do_reply  = 1'b0;
    reply_hdr = HDR_NAK;
    lenv      = '0;
    c1 = '0;
    c2 = '0;
    c3 = '0;
    c4 = '0;
    wr_o      = '0;
    job_o     = '0;

    if (in_i.mode == MODE_RELEASE) begin
      lock_d = 1'b0;
    end else if (in_i.mode == MODE_LINE) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (c == SYNC_VALUE) begin
            phase_d = PH_SYNC;
            abort_d = 1'b0;
          end
        end
        PH_SYNC: begin
          hdr2_d = c;
          if ((c & HDR2_MASK) != HDR2_VALUE) begin
            bad = 1'b1;
          end else begin
            ack_d   = (c[1:0] == 2'd1);
            crc_d   = crc8_feed(8'd0, c);
            phase_d = PH_HDR2;
          end
        end
        PH_HDR2: begin
          hdr1_d = c;
          if ((c & HDR1_MASK) != HDR1_VALUE) begin
            bad = 1'b1;
          end else begin
            lenv = {1'b0, c[3:0]};
            if (lenv > DEPTH_L) lenv = DEPTH_L;
            len_d   = lenv;
            crc_d   = crc8_feed(crc_q, c);
            phase_d = PH_HDR1;
          end
        end
        PH_HDR1: begin
          if (!ours) begin
            job_o.tx_valid = 1'b1;
            job_o.last_idx = 4'd3;
            job_o.msg[0]   = SYNC_VALUE;
            job_o.msg[1]   = hdr2_q;
            job_o.msg[2]   = hdr1_q;
            job_o.msg[3]   = c;
            phase_d        = PH_PASS_SRC;
            ack_d          = 1'b0;
            pass_d         = 1'b1;
          end else begin
            dest_d  = c;
            crc_d   = crc8_feed(crc_q, c);
            phase_d = PH_DEST;
          end
        end
        PH_DEST: begin
          if (lock_q) begin
            do_reply  = 1'b1;
            reply_hdr = HDR_NAK;
            ack_d     = 1'b0;
            abort_d   = 1'b1;
            phase_d   = PH_IDLE;
          end else begin
            src_d   = c;
            fill_d  = '0;
            crc_d   = crc8_feed(crc_q, c);
            phase_d = (len_q == 5'd0) ? PH_CRC : PH_DATA;
          end
        end
        PH_DATA: begin
          wr_o.en   = (fill_q < DEPTH_L);
          wr_o.addr = fill_q[3:0];
          wr_o.data = c;
          fill_d    = fill_q + 5'd1;
          crc_d     = crc8_feed(crc_q, c);
          if (fill_d >= len_q) phase_d = PH_CRC;
        end
        PH_CRC: begin
          if (c == crc_q) begin
            reply_hdr = HDR_ACK;
            lock_d    = 1'b1;
          end else begin
            reply_hdr = HDR_NAK;
          end
          if (ack_q) begin
            do_reply = 1'b1;
            ack_d    = 1'b0;
          end
          phase_d = PH_IDLE;
        end
        PH_PASS_SRC: begin
          job_o.tx_valid = 1'b1;
          job_o.msg[0]   = c;
          len_d          = len_q + 5'd1;
          phase_d        = PH_PASS_DATA;
        end
        PH_PASS_DATA: begin
          job_o.tx_valid = 1'b1;
          job_o.msg[0]   = c;
          if (len_q > 5'd1) begin
            len_d = len_q - 5'd1;
          end else begin
            phase_d = PH_IDLE;
            pass_d  = 1'b0;
          end
        end
        default: bad = 1'b1;
      endcase
    end

    // bad header: wipe burst unless this frame was already refused
    if (bad) begin
      if (!abort_q) begin
        job_o.tx_valid = 1'b1;
        job_o.last_idx = 4'(WIPE_CNT - 1);
      end
      ack_d   = 1'b0;
      lock_d  = 1'b0;
      pass_d  = 1'b0;
      phase_d = PH_IDLE;
    end

    // ack or nak frame with its own crc
    if (do_reply) begin
      c1 = crc8_feed(8'd0, reply_hdr);
      c2 = crc8_feed(c1, HDR1_VALUE);
      c3 = crc8_feed(c2, src_q);
      c4 = crc8_feed(c3, dest_q);
      job_o.tx_valid = 1'b1;
      job_o.last_idx = 4'(MSG_LEN - 1);
      job_o.msg[0]   = SYNC_VALUE;
      job_o.msg[1]   = reply_hdr;
      job_o.msg[2]   = HDR1_VALUE;
      job_o.msg[3]   = src_q;
      job_o.msg[4]   = dest_q;
      job_o.msg[5]   = c4;
      crc_d          = c4;
    end

    job_o.lock = lock_d;
    job_o.dest = dest_d;
    job_o.src  = src_d;
    job_o.len  = len_d;
    job_o.pass = pass_d;
    if (!accept_i) wr_o.en = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      crc_q   <= '0;
      hdr2_q  <= '0;
      hdr1_q  <= '0;
      dest_q  <= '0;
      src_q   <= '0;
      len_q   <= '0;
      fill_q  <= '0;
      ack_q   <= 1'b0;
      lock_q  <= 1'b0;
      abort_q <= 1'b0;
      pass_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      crc_q   <= crc_d;
      hdr2_q  <= hdr2_d;
      hdr1_q  <= hdr1_d;
      dest_q  <= dest_d;
      src_q   <= src_d;
      len_q   <= len_d;
      fill_q  <= fill_d;
      ack_q   <= ack_d;
      lock_q  <= lock_d;
      abort_q <= abort_d;
      pass_q  <= pass_d;
    end
  end

endmodule

>>> src/rprc_tx.sv
// rprc_tx: burst register that plays out the result items of one input transfer
// depends on rprc_pkg; read data comes from rprc_payload_ram
module rprc_tx
  import rprc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  rprc_job_t  job_i,
  input  logic [7:0] rd_data_i,
  output logic       busy_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output rprc_out_t  out_data_o
);

  rprc_job_t  job_q;
  logic       valid_q;
  logic [3:0] cnt_q;
  logic       is_last, done;
  logic [7:0] tx_sel;

  assign is_last = (cnt_q == job_q.last_idx);
  assign done    = valid_q & ~out_stall_i & is_last;
  // free for a new transfer once the final item of this burst leaves
  assign busy_o  = valid_q & ~done;

  always_comb begin
    if (cnt_q < 4'(MSG_LEN)) begin
      tx_sel = job_q.msg[cnt_q[2:0]];
    end else begin
      tx_sel = '0;
    end
  end

  assign out_valid_o                = valid_q;
  assign out_data_o.tx_byte         = tx_sel;
  assign out_data_o.tx_valid        = job_q.tx_valid;
  assign out_data_o.last            = is_last;
  assign out_data_o.packet_ready    = job_q.lock;
  assign out_data_o.read_data       = rd_data_i;
  assign out_data_o.dest_address    = job_q.dest;
  assign out_data_o.src_address     = job_q.src;
  assign out_data_o.payload_length  = job_q.len;
  assign out_data_o.passing_through = job_q.pass;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else if (accept_i) begin
      valid_q <= 1'b1;
      cnt_q   <= '0;
    end else if (done) begin
      valid_q <= 1'b0;
    end else if (valid_q && !out_stall_i) begin
      cnt_q <= cnt_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      job_q <= job_i;
    end
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking bench for ring_packet_receiver_crc8, with its own frame-level
// prediction of line bytes, apb address setup, random idling and a long output hold
// depends on rprc_pkg and the ring_packet_receiver_crc8 rtl
module tb_top;
  import rprc_pkg::*;

  localparam logic [1:0] MODE_READ     = 2'd2;
  localparam logic [1:0] MODE_NOP      = 2'd3;
  localparam logic [7:0] CRC_POLY_REFL = 8'h8c;
  localparam int         LONG_HOLD     = 300;
  localparam int         DRAIN_LIMIT   = 40000;

  typedef enum logic [3:0] {
    RX_HUNT, RX_HDR2, RX_HDR1, RX_DEST, RX_SRC, RX_DATA, RX_CRC, FWD_SRC, FWD_DATA
  } rx_phase_e;

  typedef struct {
    rprc_out_t want;
    bit        rd_known;
  } due_item_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  rprc_in_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  rprc_out_t   out_data_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [4:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  ring_packet_receiver_crc8 dut (.*);

  // receiver state as predicted
  rx_phase_e  rx_ph       = RX_HUNT;
  logic [7:0] frame_crc   = '0;
  logic [7:0] hdr_two     = '0;
  logic [7:0] hdr_one     = '0;
  logic [7:0] dest_q      = '0;
  logic [7:0] src_q       = '0;
  logic [4:0] len_q       = '0;
  logic [4:0] fill_q      = '0;
  logic [7:0] pay_mem [16];
  logic [15:0] pay_written = '0;
  bit         want_ack    = 1'b0;
  bit         locked      = 1'b0;
  bit         aborted     = 1'b0;
  bit         forwarding  = 1'b0;
  logic [2:0] own_count   = '0;
  logic [7:0] own_addr [4] = '{default: 8'h00};
  logic [7:0] tx_bytes [$];

  due_item_t  out_items_due [$];
  rprc_in_t   pending [$];
  int         items_queued  = 0;
  int         safe_top      = -1;
  bit         side_items_on = 1'b0;
  int         fail_count    = 0;

  bit         sender_idle = 1'b1;
  bit         rcv_idle    = 1'b1;
  bit         hold_asked  = 1'b0;
  bit         hold_done   = 1'b0;
  int         rcv_wait    = 0;
  int         in_gap      = 0;
  bit         in_took     = 1'b0;
  bit         out_took    = 1'b0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
    logic [7:0] r;
    r = crc ^ b;
    for (int i = 0; i < 8; i++) r = r[0] ? ((r >> 1) ^ CRC_POLY_REFL) : (r >> 1);
    return r;
  endfunction

  function automatic int owned_slots();
    return (own_count > ADDR_USED) ? ADDR_USED : int'(own_count);
  endfunction

  task automatic drop_frame();
    if (!aborted) repeat (WIPE_CNT) tx_bytes.push_back(8'h00);
    want_ack   = 1'b0;
    locked     = 1'b0;
    forwarding = 1'b0;
    rx_ph      = RX_HUNT;
  endtask

  task automatic send_reply(logic [7:0] hdr);
    frame_crc = crc8_step(8'h00, hdr);
    frame_crc = crc8_step(frame_crc, HDR1_VALUE);
    frame_crc = crc8_step(frame_crc, src_q);
    frame_crc = crc8_step(frame_crc, dest_q);
    tx_bytes.push_back(SYNC_VALUE);
    tx_bytes.push_back(hdr);
    tx_bytes.push_back(HDR1_VALUE);
    tx_bytes.push_back(src_q);
    tx_bytes.push_back(dest_q);
    tx_bytes.push_back(frame_crc);
  endtask

  // walks one accepted transfer through the frame and queues its result items
  task automatic advance_receiver(rprc_in_t it);
    logic [7:0] c;
    logic [7:0] hdr;
    bit         hit;
    int         n;
    due_item_t  d;
    c = it.rx_byte;
    tx_bytes.delete();
    if (it.mode == MODE_LINE) begin
      case (rx_ph)
        RX_HUNT: begin
          if (c == SYNC_VALUE) begin
            rx_ph   = RX_HDR2;
            aborted = 1'b0;
          end
        end
        RX_HDR2: begin
          hdr_two = c;
          if ((c & HDR2_MASK) != HDR2_VALUE) begin
            drop_frame();
          end else begin
            want_ack  = (c[1:0] == 2'b01);
            frame_crc = crc8_step(8'h00, c);
            rx_ph     = RX_HDR1;
          end
        end
        RX_HDR1: begin
          hdr_one = c;
          if ((c & HDR1_MASK) != HDR1_VALUE) begin
            drop_frame();
          end else begin
            // a nibble never exceeds the buffer depth, so no clamp bites here
            len_q     = {1'b0, c[3:0]};
            frame_crc = crc8_step(frame_crc, c);
            rx_ph     = RX_DEST;
          end
        end
        RX_DEST: begin
          hit = 1'b0;
          for (int i = 0; i < owned_slots(); i++) if (own_addr[i] == c) hit = 1'b1;
          if (!hit) begin
            tx_bytes.push_back(SYNC_VALUE);
            tx_bytes.push_back(hdr_two);
            tx_bytes.push_back(hdr_one);
            tx_bytes.push_back(c);
            rx_ph      = FWD_SRC;
            want_ack   = 1'b0;
            forwarding = 1'b1;
          end else begin
            dest_q    = c;
            frame_crc = crc8_step(frame_crc, c);
            rx_ph     = RX_SRC;
          end
        end
        RX_SRC: begin
          if (locked) begin
            // refused: nak to the previous sender, source left as it was
            send_reply(HDR_NAK);
            want_ack = 1'b0;
            aborted  = 1'b1;
            rx_ph    = RX_HUNT;
          end else begin
            src_q     = c;
            fill_q    = '0;
            frame_crc = crc8_step(frame_crc, c);
            rx_ph     = (len_q == 0) ? RX_CRC : RX_DATA;
          end
        end
        RX_DATA: begin
          if (fill_q < RX_DEPTH) begin
            pay_mem[fill_q[3:0]]     = c;
            pay_written[fill_q[3:0]] = 1'b1;
          end
          fill_q    = fill_q + 5'd1;
          frame_crc = crc8_step(frame_crc, c);
          if (fill_q >= len_q) rx_ph = RX_CRC;
        end
        RX_CRC: begin
          if (c == frame_crc) begin
            hdr    = HDR_ACK;
            locked = 1'b1;
          end else begin
            hdr = HDR_NAK;
          end
          if (want_ack) begin
            send_reply(hdr);
            want_ack = 1'b0;
          end
          rx_ph = RX_HUNT;
        end
        FWD_SRC: begin
          tx_bytes.push_back(c);
          len_q = len_q + 5'd1;
          rx_ph = FWD_DATA;
        end
        FWD_DATA: begin
          tx_bytes.push_back(c);
          if (len_q > 1) begin
            len_q = len_q - 5'd1;
          end else begin
            rx_ph      = RX_HUNT;
            forwarding = 1'b0;
          end
        end
        default: drop_frame();
      endcase
    end else if (it.mode == MODE_RELEASE) begin
      locked = 1'b0;
    end

    n = (tx_bytes.size() > 0) ? tx_bytes.size() : 1;
    for (int k = 0; k < n; k++) begin
      d.want.tx_byte         = (tx_bytes.size() > 0) ? tx_bytes[k] : 8'h00;
      d.want.tx_valid        = (tx_bytes.size() > 0);
      d.want.last            = (k == n - 1);
      d.want.packet_ready    = locked;
      d.want.read_data       = pay_mem[it.read_index];
      d.want.dest_address    = dest_q;
      d.want.src_address     = src_q;
      d.want.payload_length  = len_q;
      d.want.passing_through = forwarding;
      d.rd_known             = pay_written[it.read_index];
      out_items_due.push_back(d);
    end
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // driver: one transfer per pending item, gap drawn per item
  always @(negedge clk_i) begin : feed
    if (!(in_valid_i && !in_took)) begin
      if (in_gap != 0) begin
        in_valid_i <= 1'b0;
        in_gap     <= in_gap - 1;
      end else if (pending.size() != 0) begin
        in_data_i  <= pending.pop_front();
        in_valid_i <= 1'b1;
        in_gap     <= sender_idle ? $urandom_range(0, 4) : 0;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiving side: random stall after each transfer while idling is on, one long hold on request
  always @(negedge clk_i) begin : sink
    int n;
    n = 0;
    if (hold_asked && !hold_done) begin
      rcv_wait    <= LONG_HOLD;
      hold_done   <= 1'b1;
      out_stall_i <= 1'b1;
    end else if (rcv_wait != 0) begin
      rcv_wait    <= rcv_wait - 1;
      out_stall_i <= 1'b1;
    end else if (out_took && rcv_idle) begin
      n = $urandom_range(0, 4);
      rcv_wait    <= (n > 0) ? n - 1 : 0;
      out_stall_i <= (n > 0);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : watch
    due_item_t due;
    in_took  <= in_valid_i && !in_stall_o;
    out_took <= out_valid_o && !out_stall_i;
    if (out_valid_o && !out_stall_i) begin
      if (out_items_due.size() == 0) begin
        $error("result item with nothing outstanding, tx_byte %0h", out_data_o.tx_byte);
        fail_count++;
      end else begin
        due = out_items_due.pop_front();
        check_field("tx_byte", due.want.tx_byte, out_data_o.tx_byte);
        check_field("tx_valid", 8'(due.want.tx_valid), 8'(out_data_o.tx_valid));
        check_field("last", 8'(due.want.last), 8'(out_data_o.last));
        check_field("packet_ready", 8'(due.want.packet_ready),
                    8'(out_data_o.packet_ready));
        if (due.rd_known) check_field("read_data", due.want.read_data, out_data_o.read_data);
        check_field("dest_address", due.want.dest_address, out_data_o.dest_address);
        check_field("src_address", due.want.src_address, out_data_o.src_address);
        check_field("payload_length", 8'(due.want.payload_length),
                    8'(out_data_o.payload_length));
        check_field("passing_through", 8'(due.want.passing_through),
                    8'(out_data_o.passing_through));
      end
    end
    if (in_valid_i && !in_stall_o) advance_receiver(in_data_i);
  end

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_COUNT) own_count = val[2:0];
    else own_addr[idx - REG_ADDR0] = val;
  endtask

  task automatic apply_setting(logic [7:0] cnt, logic [7:0] a0, logic [7:0] a1,
                               logic [7:0] a2, logic [7:0] a3);
    write_reg(REG_COUNT, cnt);
    write_reg(REG_ADDR0, a0);
    write_reg(REG_ADDR1, a1);
    write_reg(REG_ADDR2, a2);
    write_reg(REG_ADDR3, a3);
  endtask

  // reads stay at or below the highest payload index that a queued frame carries
  function automatic logic [3:0] pick_index();
    return (safe_top < 0) ? 4'd0 : 4'($urandom_range(0, safe_top));
  endfunction

  function automatic void queue_item(logic [1:0] m, logic [7:0] c, logic [3:0] idx);
    rprc_in_t it;
    it.mode       = m;
    it.rx_byte    = c;
    it.read_index = idx;
    pending.push_back(it);
    if (m != MODE_NOP) items_queued++;
  endfunction

  function automatic void queue_line(logic [7:0] c);
    if (side_items_on && $urandom_range(0, 11) == 0)
      queue_item(2'($urandom_range(1, 3)), 8'($urandom), pick_index());
    queue_item(MODE_LINE, c, pick_index());
  endfunction

  function automatic void queue_frame(logic [7:0] dst, logic [7:0] srcb, logic [1:0] low,
                                      logic [3:0] len, bit crc_ok);
    logic [7:0] crc;
    logic [7:0] b;
    queue_line(SYNC_VALUE);
    queue_line(HDR2_VALUE | {6'd0, low});
    crc = crc8_step(8'h00, HDR2_VALUE | {6'd0, low});
    queue_line(HDR1_VALUE | {4'd0, len});
    crc = crc8_step(crc, HDR1_VALUE | {4'd0, len});
    queue_line(dst);
    crc = crc8_step(crc, dst);
    queue_line(srcb);
    crc = crc8_step(crc, srcb);
    for (int k = 0; k < len; k++) begin
      b = 8'($urandom);
      if (k > safe_top) safe_top = k;
      queue_line(b);
      crc = crc8_step(crc, b);
    end
    if (!crc_ok) crc = crc ^ 8'($urandom_range(1, 255));
    queue_line(crc);
  endfunction

  task automatic queue_random(int quota);
    int         start;
    int         r;
    int         lim;
    logic [7:0] b;
    logic [7:0] dst;
    logic [1:0] low;
    logic [3:0] len;
    start = items_queued;
    while (items_queued - start < quota) begin
      r = $urandom_range(0, 19);
      if (r < 13) begin
        lim = owned_slots();
        if (lim != 0 && $urandom_range(0, 3) != 0) dst = own_addr[$urandom_range(0, lim - 1)];
        else dst = 8'($urandom);
        low = ($urandom_range(0, 2) == 0) ? 2'($urandom_range(0, 3)) : 2'b01;
        len = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(5, 15)) : 4'($urandom_range(0, 4));
        queue_frame(dst, 8'($urandom), low, len, $urandom_range(0, 4) != 0);
        if ($urandom_range(0, 1) == 1) queue_item(MODE_RELEASE, 8'($urandom), pick_index());
      end else if (r < 15) begin
        // broken frame: a bad first or second header byte
        queue_line(SYNC_VALUE);
        b = 8'($urandom);
        if ($urandom_range(0, 1) == 1) begin
          if ((b & HDR2_MASK) == HDR2_VALUE) b = b ^ 8'h80;
          queue_line(b);
        end else begin
          queue_line(HDR2_VALUE | 8'($urandom_range(0, 3)));
          if ((b & HDR1_MASK) == HDR1_VALUE) b = b ^ 8'h40;
          queue_line(b);
        end
      end else if (r < 17) begin
        queue_line(8'($urandom));
      end else if (r < 19) begin
        queue_item(MODE_READ, 8'($urandom), pick_index());
      end else begin
        queue_item(MODE_NOP, 8'($urandom), pick_index());
      end
    end
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    while ((pending.size() != 0 || in_valid_i || out_items_due.size() != 0)
           && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (out_items_due.size() != 0) begin
      $error("%0d result items still outstanding", out_items_due.size());
      fail_count++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    apply_setting(8'd2, 8'h12, 8'hff, 8'h00, 8'ha5);
    // good frame with ack request fills the buffer and sets the lock
    queue_frame(8'hff, 8'h00, 2'b01, 4'd10, 1'b1);
    // next frame for us is refused while the lock is held
    queue_frame(8'h12, 8'h5a, 2'b00, 4'd0, 1'b1);
    // bad first header byte: wipe burst, lock cleared
    queue_item(MODE_LINE, SYNC_VALUE, 4'd9);
    queue_item(MODE_LINE, 8'h00, 4'd8);
    queue_item(MODE_RELEASE, 8'hff, 4'd7);
    queue_item(MODE_READ, 8'h00, 4'd8);
    queue_item(MODE_NOP, 8'hff, 4'd7);
    side_items_on = 1'b1;
    queue_random(40);
    settle();

    // no own address: every frame is forwarded, no idling at either side
    sender_idle = 1'b0;
    rcv_idle    = 1'b0;
    apply_setting(8'd0, 8'h00, 8'h00, 8'hff, 8'hff);
    queue_random(30);
    settle();

    // count above the address registers saturates
    sender_idle = 1'b1;
    rcv_idle    = 1'b1;
    apply_setting(8'd7, 8'h00, 8'h80, 8'h7f, 8'hff);
    queue_random(45);
    settle();

    // full address set; the output side holds off long enough to back up the input
    sender_idle = 1'b0;
    apply_setting(8'd4, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    queue_random(45);
    hold_asked = 1'b1;
    settle();

    if (fail_count == 0) begin
      $display("ring_packet_receiver_crc8 regression: pass");
    end else begin
      $display("ring_packet_receiver_crc8 regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("ring_packet_receiver_crc8 regression: fail");
    $finish;
  end

endmodule
